@@ sv/rpe_pkg.sv @@
package rpe_pkg;

	localparam logic [1:0] CFG_HEAD_DIM  = 2'd0;
	localparam logic [1:0] CFG_SEQ_LEN   = 2'd1;
	localparam logic [1:0] CFG_NUM_HEADS = 2'd2;

	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	// Result pairs that may be in flight or queued at once.
	localparam int QDEPTH = 32;

	typedef struct packed {
		logic [15:0] r1;
		logic [15:0] r2;
		logic [6:0]  pair;
		logic [6:0]  dim;
	} res_t;

endpackage

@@ sv/rotary_position_embedding.sv @@
// A pair's first result is offered once its second element has passed the table
// read, lane and queue registers; the second follows once the first is taken.
// Throughput: one item per cycle; input ready drops while 32 result pairs are in
// the arithmetic pipeline or the output queue, so a sustained rate is set by the
// output port taking one result per cycle.
// Reset clears counters and valid bits; the table, pair buffer and data are not.
module rotary_position_embedding
	import rpe_pkg::*;
#(
	parameter int MAX_POSITIONS = 1024,
	parameter int MAX_HALF_DIM  = 64
)
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [10:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        req_type,
	input  logic [15:0] table_index,
	input  logic [15:0] cos_value,
	input  logic [15:0] sin_value,
	input  logic [15:0] query_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] rotated_value,
	output logic [6:0]  dim_index,
	output logic        last_of_run
);

	localparam int PW  = (MAX_POSITIONS > 1) ? $clog2(MAX_POSITIONS) : 1;
	localparam int PIW = (MAX_HALF_DIM > 1) ? $clog2(MAX_HALF_DIM) : 1;
	localparam int DW  = $clog2(2 * MAX_HALF_DIM);
	localparam int AW  = PW + 10;
	localparam int CW  = $clog2(QDEPTH + 1);
	localparam logic [9:0]  MAXH = 10'(MAX_HALF_DIM);
	localparam logic [16:0] MAXP = 17'(MAX_POSITIONS);

	typedef struct packed {
		logic [6:0] pair;
		logic [6:0] dim;
	} tag_t;

	logic [7:0]  head_dim_q;
	logic [10:0] seq_len_q;
	logic [8:0]  num_heads_q;

	logic [DW-1:0] dim_q;
	logic [7:0]    head_q;
	logic [PW-1:0] pos_q;
	logic [CW-1:0] inflight_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_dim_q <= 8'd128;
			seq_len_q <= 11'd1024;
			num_heads_q <= 9'd32;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_HEAD_DIM:  head_dim_q <= cfg_data[7:0];
				CFG_SEQ_LEN:   seq_len_q <= cfg_data;
				CFG_NUM_HEADS: num_heads_q <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	logic [9:0]  half_raw, half, hd;
	logic [16:0] sl;
	logic [8:0]  nh;
	logic [DW-1:0] dc;
	logic [7:0]    hc;
	logic [PW-1:0] pc;
	logic [9:0]  dn, pair_w;
	logic [8:0]  hn;
	logic [16:0] pn;
	logic        wrap_d, wrap_h, wrap_p, second;
	logic [AW-1:0] mulv, addr_full;
	logic [15:0] addr;
	logic        acc, load, query, query2;

	always_comb begin
		half_raw = {3'b000, head_dim_q[7:1]};
		if (half_raw == 10'd0) begin
			half = 10'd1;
		end else if (half_raw > MAXH) begin
			half = MAXH;
		end else begin
			half = half_raw;
		end
		hd = half << 1;
		if (seq_len_q == 11'd0) begin
			sl = 17'd1;
		end else if (17'(seq_len_q) > MAXP) begin
			sl = MAXP;
		end else begin
			sl = 17'(seq_len_q);
		end
		if (num_heads_q == 9'd0) begin
			nh = 9'd1;
		end else if (num_heads_q > 9'd256) begin
			nh = 9'd256;
		end else begin
			nh = num_heads_q;
		end
		dc = (10'(dim_q) >= hd) ? '0 : dim_q;
		hc = (9'(head_q) >= nh) ? '0 : head_q;
		pc = (17'(pos_q) >= sl) ? '0 : pos_q;
		dn = 10'(dc) + 10'd1;
		hn = 9'(hc) + 9'd1;
		pn = 17'(pc) + 17'd1;
		wrap_d = (dn >= hd);
		wrap_h = (hn >= nh);
		wrap_p = (pn >= sl);
		second = (10'(dc) >= half);
		pair_w = 10'(dc) - half;
		mulv = AW'(pc) * AW'(half);
		addr_full = mulv + AW'(pair_w);
		addr = 16'(addr_full);
	end

	assign in_ready = (inflight_q != CW'(QDEPTH));
	assign acc = in_valid & in_ready;
	assign load = acc & (req_type == REQ_LOAD);
	assign query = acc & (req_type == REQ_QUERY);
	assign query2 = query & second;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_q <= '0;
			head_q <= '0;
			pos_q <= '0;
		end else if (query) begin
			dim_q <= wrap_d ? '0 : dn[DW-1:0];
			if (wrap_d) begin
				head_q <= wrap_h ? '0 : hn[7:0];
				pos_q <= wrap_h ? (wrap_p ? '0 : pn[PW-1:0]) : pc;
			end else begin
				head_q <= hc;
				pos_q <= pc;
			end
		end
	end

	// Angle table and first-half element buffer.
	logic [31:0] angle_mem [65536];
	logic [15:0] half_mem [MAX_HALF_DIM];
	logic [31:0] tab_rd_s1;
	logic [15:0] buf_rd_s1;
	logic [15:0] x2_s1;

	always_ff @(posedge clk) begin
		if (load) begin
			angle_mem[table_index] <= {sin_value, cos_value};
		end else if (query2) begin
			tab_rd_s1 <= angle_mem[addr];
		end
	end

	always_ff @(posedge clk) begin
		if (query && !second) begin
			half_mem[dc[PIW-1:0]] <= query_value;
		end
		if (query2) begin
			buf_rd_s1 <= half_mem[pair_w[PIW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (query2) begin
			x2_s1 <= query_value;
		end
	end

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	tag_t tag_s1, tag_s2, tag_s3, tag_s4, tag_s5, tag_s6, tag_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else begin
			vld_s1 <= query2;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		tag_s1 <= '{pair: 7'(pair_w), dim: 7'(dc)};
		tag_s2 <= tag_s1;
		tag_s3 <= tag_s2;
		tag_s4 <= tag_s3;
		tag_s5 <= tag_s4;
		tag_s6 <= tag_s5;
		tag_s7 <= tag_s6;
	end

	logic [15:0] r1_s7, r2_s7;

	rpe_rot_lane u_lane_lo (
		.clk    (clk),
		.sub_op (1'b1),
		.a1     (buf_rd_s1),
		.b1     (tab_rd_s1[15:0]),
		.a2     (x2_s1),
		.b2     (tab_rd_s1[31:16]),
		.result (r1_s7)
	);

	rpe_rot_lane u_lane_hi (
		.clk    (clk),
		.sub_op (1'b0),
		.a1     (x2_s1),
		.b1     (tab_rd_s1[15:0]),
		.a2     (buf_rd_s1),
		.b2     (tab_rd_s1[31:16]),
		.result (r2_s7)
	);

	res_t push_data;
	logic pair_done;

	assign push_data = '{r1: r1_s7, r2: r2_s7, pair: tag_s7.pair, dim: tag_s7.dim};

	rpe_res_fifo u_fifo (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (vld_s7),
		.push_data     (push_data),
		.out_ready     (out_ready),
		.out_valid     (out_valid),
		.rotated_value (rotated_value),
		.dim_index     (dim_index),
		.last_of_run   (last_of_run),
		.pair_done     (pair_done)
	);

	// Pairs in the pipeline plus pairs waiting in the queue.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			inflight_q <= inflight_q + CW'(query2) - CW'(pair_done);
		end
	end

	a_inflight_bound: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= CW'(QDEPTH))
		else $error("in-flight pair count exceeds queue depth");

	a_push_counted: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s7 |-> inflight_q != '0)
		else $error("result pair pushed without an in-flight transaction");

	a_out_counted: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> inflight_q != '0)
		else $error("result offered without an in-flight transaction");

	a_dim_range: assert property (@(posedge clk) disable iff (!arst_n)
		query |=> 10'(dim_q) < hd)
		else $error("dimension counter beyond head size");

endmodule

@@ sv/rpe_rot_lane.sv @@
module rpe_rot_lane
	import rpe_pkg::*;
(
	input  logic        clk,
	input  logic        sub_op,
	input  logic [15:0] a1,
	input  logic [15:0] b1,
	input  logic [15:0] a2,
	input  logic [15:0] b2,
	output logic [15:0] result
);

	localparam logic [15:0] FP16_DEFAULT_NAN = 16'hFE00;

	typedef struct packed {
		logic        nan;
		logic        inf;
		logic        sign;
		logic [15:0] code;
	} pspec_t;

	function automatic logic [10:0] fmag(input logic [15:0] h);
		fmag = {h[14:10] != 5'd0, h[9:0]};
	endfunction

	function automatic logic [4:0] fexp(input logic [15:0] h);
		fexp = (h[14:10] == 5'd0) ? 5'd1 : h[14:10];
	endfunction

	function automatic logic fnan(input logic [15:0] h);
		fnan = (&h[14:10]) && (|h[9:0]);
	endfunction

	function automatic logic finf(input logic [15:0] h);
		finf = (&h[14:10]) && !(|h[9:0]);
	endfunction

	function automatic logic fzero(input logic [15:0] h);
		fzero = !(|h[14:0]);
	endfunction

	function automatic pspec_t prod_spec(input logic [15:0] a, input logic [15:0] b);
		pspec_t r;
		r.sign = a[15] ^ b[15];
		r.nan = 1'b0;
		r.inf = 1'b0;
		r.code = 16'h0000;
		if (fnan(a)) begin
			r.nan = 1'b1;
			r.code = {a[15], 6'h3F, a[8:0]};
		end else if (fnan(b)) begin
			r.nan = 1'b1;
			r.code = {b[15], 6'h3F, b[8:0]};
		end else if ((finf(a) && fzero(b)) || (fzero(a) && finf(b))) begin
			r.nan = 1'b1;
			r.code = FP16_DEFAULT_NAN;
		end else if (finf(a) || finf(b)) begin
			r.inf = 1'b1;
		end
		prod_spec = r;
	endfunction

	// Stage 2: exact products and special operands.
	logic [21:0] prod1_s2, prod2_s2;
	logic [5:0]  exp1_s2, exp2_s2;
	logic        sg1_s2, sg2_s2;
	logic        spec_s2;
	logic [15:0] code_s2;

	pspec_t      p1, p2;
	logic        sg2e;
	logic        spec_c;
	logic [15:0] code_c;

	always_comb begin
		p1 = prod_spec(a1, b1);
		p2 = prod_spec(a2, b2);
		sg2e = p2.sign ^ sub_op;
		spec_c = 1'b1;
		code_c = 16'h0000;
		if (p1.nan) begin
			code_c = p1.code;
		end else if (p2.nan) begin
			code_c = p2.code;
		end else if (p1.inf && p2.inf) begin
			code_c = (p1.sign == sg2e) ? {p1.sign, 15'h7C00} : FP16_DEFAULT_NAN;
		end else if (p1.inf) begin
			code_c = {p1.sign, 15'h7C00};
		end else if (p2.inf) begin
			code_c = {sg2e, 15'h7C00};
		end else begin
			spec_c = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		prod1_s2 <= 22'(fmag(a1)) * 22'(fmag(b1));
		prod2_s2 <= 22'(fmag(a2)) * 22'(fmag(b2));
		exp1_s2  <= 6'(fexp(a1)) + 6'(fexp(b1));
		exp2_s2  <= 6'(fexp(a2)) + 6'(fexp(b2));
		sg1_s2   <= p1.sign;
		sg2_s2   <= sg2e;
		spec_s2  <= spec_c;
		code_s2  <= code_c;
	end

	// Stage 3: align both products on a common fixed point grid and add.
	logic signed [81:0] sum_s3;
	logic        zsign_s3;
	logic        spec_s3;
	logic [15:0] code_s3;

	logic [79:0] f1, f2;
	logic [81:0] v1, v2;

	always_comb begin
		f1 = 80'(prod1_s2) << (exp1_s2 - 6'd2);
		f2 = 80'(prod2_s2) << (exp2_s2 - 6'd2);
		v1 = sg1_s2 ? -{2'b00, f1} : {2'b00, f1};
		v2 = sg2_s2 ? -{2'b00, f2} : {2'b00, f2};
	end

	always_ff @(posedge clk) begin
		sum_s3   <= $signed(v1 + v2);
		zsign_s3 <= sg1_s2 & sg2_s2;
		spec_s3  <= spec_s2;
		code_s3  <= code_s2;
	end

	// Stage 4: magnitude and the coarse normalizing shifts.
	logic [80:0] norm_s4;
	logic [6:0]  sc_s4;
	logic        sign_s4, zero_s4;
	logic        spec_s4;
	logic [15:0] code_s4;

	logic [81:0] neg_sum;
	logic [80:0] mag, n4;
	logic [6:0]  c4;

	always_comb begin
		neg_sum = -sum_s3;
		mag = sum_s3[81] ? neg_sum[80:0] : sum_s3[80:0];
		n4 = mag;
		c4 = 7'd0;
		if (n4[80:17] == '0) begin
			n4 = n4 << 64;
			c4 = c4 | 7'd64;
		end
		if (n4[80:49] == '0) begin
			n4 = n4 << 32;
			c4 = c4 | 7'd32;
		end
	end

	always_ff @(posedge clk) begin
		norm_s4 <= n4;
		sc_s4   <= c4;
		zero_s4 <= (mag == '0);
		sign_s4 <= (mag == '0) ? zsign_s3 : sum_s3[81];
		spec_s4 <= spec_s3;
		code_s4 <= code_s3;
	end

	// Stage 5: fine normalizing shifts.
	logic [80:0] norm_s5;
	logic [6:0]  sc_s5;
	logic        sign_s5, zero_s5;
	logic        spec_s5;
	logic [15:0] code_s5;

	logic [80:0] n5;
	logic [6:0]  c5;

	always_comb begin
		n5 = norm_s4;
		c5 = sc_s4;
		if (n5[80:65] == '0) begin
			n5 = n5 << 16;
			c5 = c5 | 7'd16;
		end
		if (n5[80:73] == '0) begin
			n5 = n5 << 8;
			c5 = c5 | 7'd8;
		end
		if (n5[80:77] == '0) begin
			n5 = n5 << 4;
			c5 = c5 | 7'd4;
		end
		if (n5[80:79] == '0) begin
			n5 = n5 << 2;
			c5 = c5 | 7'd2;
		end
		if (!n5[80]) begin
			n5 = n5 << 1;
			c5 = c5 | 7'd1;
		end
	end

	always_ff @(posedge clk) begin
		norm_s5 <= n5;
		sc_s5   <= c5;
		zero_s5 <= zero_s4;
		sign_s5 <= sign_s4;
		spec_s5 <= spec_s4;
		code_s5 <= code_s4;
	end

	// Stage 6: round to single precision, nearest even.
	logic [23:0]       man_s6;
	logic signed [8:0] exp_s6;
	logic        sign_s6, zero_s6;
	logic        spec_s6;
	logic [15:0] code_s6;

	logic [24:0] sig25;
	logic        rinc;

	always_comb begin
		rinc = norm_s5[56] & ((|norm_s5[55:0]) | norm_s5[57]);
		sig25 = {1'b0, norm_s5[80:57]} + 25'(rinc);
	end

	always_ff @(posedge clk) begin
		man_s6  <= sig25[24] ? 24'h800000 : sig25[23:0];
		exp_s6  <= $signed(9'd32 + 9'(sig25[24]) - {2'b00, sc_s5});
		zero_s6 <= zero_s5;
		sign_s6 <= sign_s5;
		spec_s6 <= spec_s5;
		code_s6 <= code_s5;
	end

	// Stage 7: round to half precision, nearest even.
	logic [15:0] result_s7;

	logic signed [8:0] nsh;
	logic [4:0]  sh;
	logic [48:0] tmp;
	logic [11:0] qr;
	logic [15:0] val;
	logic [4:0]  ebias;
	logic [15:0] h_c;

	always_comb begin
		nsh = -exp_s6 - 9'sd1;
		sh = (exp_s6 >= -9'sd14) ? 5'd13 : nsh[4:0];
		tmp = {man_s6, 25'b0} >> sh;
		qr = tmp[36:25] + 12'(tmp[24] & ((|tmp[23:0]) | tmp[25]));
		ebias = 5'(exp_s6 + 9'sd14);
		val = {1'b0, ebias, 10'b0} + {4'b0, qr};
		if (spec_s6) begin
			h_c = code_s6;
		end else if (zero_s6) begin
			h_c = {sign_s6, 15'h0000};
		end else if (exp_s6 > 9'sd15) begin
			h_c = {sign_s6, 15'h7C00};
		end else if (exp_s6 < -9'sd14) begin
			if (nsh > 9'sd24) begin
				h_c = {sign_s6, 15'h0000};
			end else begin
				h_c = {sign_s6, 4'b0, qr[10:0]};
			end
		end else if (val >= 16'h7C00) begin
			h_c = {sign_s6, 15'h7C00};
		end else begin
			h_c = {sign_s6, val[14:0]};
		end
	end

	always_ff @(posedge clk) begin
		result_s7 <= h_c;
	end

	assign result = result_s7;

endmodule

@@ sv/rpe_res_fifo.sv @@
module rpe_res_fifo
	import rpe_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  res_t        push_data,
	input  logic        out_ready,
	output logic        out_valid,
	output logic [15:0] rotated_value,
	output logic [6:0]  dim_index,
	output logic        last_of_run,
	output logic        pair_done
);

	localparam int PTRW = $clog2(QDEPTH);

	res_t              entry_q [QDEPTH];
	logic [PTRW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [PTRW:0]     count_q;
	logic              sel_q;
	logic              take;
	res_t              head;

	assign head = entry_q[rd_ptr_q];
	assign out_valid = (count_q != '0);
	assign take = out_valid & out_ready;
	assign pair_done = take & sel_q;
	assign rotated_value = sel_q ? head.r2 : head.r1;
	assign dim_index = sel_q ? head.dim : head.pair;
	assign last_of_run = sel_q;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
			sel_q <= 1'b0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pair_done) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (take) begin
				sel_q <= ~sel_q;
			end
			count_q <= count_q + (PTRW+1)'(push) - (PTRW+1)'(pair_done);
		end
	end

endmodule
